// File: rtl/core/mafs_pkg.sv
// Package: shared types, constants and header decode tables for the frame sync decoder.
package mafs_pkg;

  localparam int SkipCountBits = 24;
  localparam int SkipOutBits   = 24;

  localparam logic [31:0] SYNC_WORD_BITS = 32'hFFE00000;
  localparam logic [31:0] TEMPLATE_MASK  = 32'hFFFF0C00;

  localparam logic [1:0] REG_TEMPLATE   = 2'd0;
  localparam logic [1:0] REG_MAX_SEARCH = 2'd1;

  localparam logic STATUS_FOUND   = 1'b0;
  localparam logic STATUS_OVERRUN = 1'b1;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic                   overrun;
    logic [SkipOutBits-1:0] skip;
    logic [31:0]            header;
  } mafs_cand_t;

  typedef struct packed {
    logic                   status;
    logic [SkipOutBits-1:0] skipped_bytes;
    logic [31:0]            header_word;
    logic [1:0]             mpeg_version;
    logic [1:0]             layer_index;
    logic [8:0]             bitrate_kbps;
    logic [15:0]            sample_rate_hz;
    logic [10:0]            frame_bytes;
    logic [6:0]             frame_time_ms;
  } mafs_result_t;

  function automatic logic header_ok(input logic [31:0] h);
    logic ok;
    ok = ((h & SYNC_WORD_BITS) == SYNC_WORD_BITS);
    if (h[20:19] == 2'b01) ok = 1'b0;
    if (h[18:17] == 2'b00) ok = 1'b0;
    if (h[15:12] == 4'hF || h[15:12] == 4'h0) ok = 1'b0;
    if (h[11:10] == 2'b11) ok = 1'b0;
    if (h[19] && h[18:17] == 2'b11 && h[16]) ok = 1'b0;
    if (h[31:16] == 16'hFFFE) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [8:0] rate_lookup(input logic tab, input logic [1:0] lay,
                                             input logic [3:0] bi);
    logic [8:0] r;
    r = 9'd0;
    if (!tab && lay == 2'd0) begin
      r = (bi == 4'd15) ? 9'd0 : {bi, 5'd0};
    end else if (!tab && lay == 2'd1) begin
      case (bi)
        4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;   4'd4: r = 9'd64;
        4'd5: r = 9'd80;   4'd6: r = 9'd96;   4'd7: r = 9'd112;  4'd8: r = 9'd128;
        4'd9: r = 9'd160;  4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
        4'd13: r = 9'd320; 4'd14: r = 9'd384;
        default: r = 9'd0;
      endcase
    end else if (!tab) begin
      case (bi)
        4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;   4'd4: r = 9'd56;
        4'd5: r = 9'd64;   4'd6: r = 9'd80;   4'd7: r = 9'd96;   4'd8: r = 9'd112;
        4'd9: r = 9'd128;  4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
        4'd13: r = 9'd256; 4'd14: r = 9'd320;
        default: r = 9'd0;
      endcase
    end else if (lay == 2'd0) begin
      case (bi)
        4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;   4'd4: r = 9'd64;
        4'd5: r = 9'd80;   4'd6: r = 9'd96;   4'd7: r = 9'd112;  4'd8: r = 9'd128;
        4'd9: r = 9'd144;  4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
        4'd13: r = 9'd224; 4'd14: r = 9'd256;
        default: r = 9'd0;
      endcase
    end else begin
      case (bi)
        4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;   4'd4: r = 9'd32;
        4'd5: r = 9'd40;   4'd6: r = 9'd48;   4'd7: r = 9'd56;   4'd8: r = 9'd64;
        4'd9: r = 9'd80;   4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
        4'd13: r = 9'd144; 4'd14: r = 9'd160;
        default: r = 9'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] fs_lookup(input logic [1:0] ver, input logic [1:0] fi);
    logic [15:0] f;
    f = 16'd0;
    case ({ver, fi})
      4'b0000: f = 16'd11025; 4'b0001: f = 16'd12000; 4'b0010: f = 16'd8000;
      4'b0100: f = 16'd44100; 4'b0101: f = 16'd48000; 4'b0110: f = 16'd32000;
      4'b1000: f = 16'd22050; 4'b1001: f = 16'd24000; 4'b1010: f = 16'd16000;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/mafs_front.sv
// Front part: byte window, search counter, limit test and header classification.
module mafs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [7:0]               data_byte,
  input  logic                     restart,
  input  logic [31:0]              template_header,
  input  logic [23:0]              max_search,
  output logic                     cand_valid,
  output mafs_pkg::mafs_cand_t     cand
);

  localparam int CB = mafs_pkg::SkipCountBits;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  logic [31:0]   header_window;
  logic [CB-1:0] bytes_in_search;
  logic [31:0]   win_base, win_new, tmpl;
  logic [CB-1:0] prev, cnt_inc;
  logic          checked, overrun, match;
  logic [CB-1:0] skip_full;

  // Limit test in a common 33-bit domain so any counter width compares cleanly.
  always_comb begin
    win_base  = restart ? 32'd0 : header_window;
    prev      = restart ? '0 : bytes_in_search;
    win_new   = {win_base[23:0], data_byte};
    cnt_inc   = (prev == CNT_MAX) ? prev : prev + 1'b1;
    checked   = (prev >= CB'(3));
    overrun   = checked && (max_search != 24'd0) && (33'(prev) >= 33'(max_search));
    tmpl      = template_header & mafs_pkg::TEMPLATE_MASK;
    match     = checked && mafs_pkg::header_ok(win_new) &&
                (tmpl == 32'd0 || (win_new & mafs_pkg::TEMPLATE_MASK) == tmpl);
    skip_full = cnt_inc - CB'(4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_window   <= 32'd0;
      bytes_in_search <= '0;
      cand_valid      <= 1'b0;
    end else begin
      cand_valid <= 1'b0;
      if (in_valid) begin
        if (overrun || match) begin
          header_window   <= 32'd0;
          bytes_in_search <= '0;
          cand_valid      <= 1'b1;
        end else begin
          header_window   <= win_new;
          bytes_in_search <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      cand.overrun <= overrun;
      cand.header  <= win_new;
      if (33'(skip_full) > 33'(24'hFFFFFF)) cand.skip <= 24'hFFFFFF;
      else cand.skip <= 24'(skip_full);
    end
  end

endmodule

// File: rtl/core/mafs_back.sv
// Back part: queue of candidates and serial frame length/time computation.
module mafs_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cand_valid,
  input  mafs_pkg::mafs_cand_t     cand,
  output logic                     q_full,
  output logic                     res_valid,
  input  logic                     res_pop,
  output mafs_pkg::mafs_result_t   res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Two-entry candidate queue.
  mafs_pkg::mafs_cand_t qmem [2];
  logic       wp, rp;
  logic [1:0] qcnt;
  logic       deq;

  logic [1:0]  state;
  mafs_pkg::mafs_cand_t cur;
  mafs_pkg::mafs_result_t res_next;
  logic [1:0]  ver, lay;
  logic        tab;
  logic [8:0]  br;
  logic [15:0] fs;
  logic [16:0] dv;
  logic [27:0] num_fb, rem_fb;
  logic [20:0] num_ft, rem_ft;
  logic [10:0] q_fb;
  logic [6:0]  q_ft;
  logic [4:0]  step;
  logic        load;

  assign q_full = (qcnt == 2'd2);
  assign deq    = (state == ST_IDLE) && (qcnt != 2'd0);
  assign load   = (state == ST_DONE) && (!res_valid || res_pop);

  always_ff @(posedge clk) begin
    if (cand_valid) qmem[wp] <= cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; qcnt <= 2'd0;
    end else begin
      if (cand_valid) wp <= ~wp;
      if (deq) rp <= ~rp;
      qcnt <= qcnt + {1'b0, cand_valid} - {1'b0, deq};
    end
  end

  // Long division: one bit per cycle; time quotient bits in later steps.
  logic [28:0] t_fb;
  logic [21:0] t_ft;
  logic [27:0] sh_fb;
  logic [20:0] sh_ft;
  always_comb begin
    sh_fb = {rem_fb[26:0], num_fb[27]};
    sh_ft = {rem_ft[19:0], num_ft[20]};
    t_fb  = {1'b0, sh_fb} - {12'd0, dv};
    t_ft  = {1'b0, sh_ft} - {5'd0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (load) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
      case (state)
        ST_IDLE: if (deq) state <= ST_MUL;
        ST_MUL:  state <= cur.overrun ? ST_DONE : ST_DIV;
        ST_DIV:  if (step == 5'd27) state <= ST_DONE;
        ST_DONE: if (load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= qmem[rp];
      end
      ST_MUL: begin
        num_fb <= 28'(br) * ((lay == 2'd0) ? 28'd48000 : 28'd144000);
        num_ft <= (lay == 2'd0) ? 21'd384000 : 21'd1152000;
        rem_fb <= '0; rem_ft <= '0;
        q_fb   <= '0; q_ft   <= '0;
        step   <= 5'd0;
        dv     <= (fs == 16'd0) ? 17'd1 : (tab ? {fs, 1'b0} : {1'b0, fs});
      end
      ST_DIV: begin
        num_fb <= {num_fb[26:0], 1'b0};
        if (!t_fb[28]) begin rem_fb <= t_fb[27:0]; q_fb <= {q_fb[9:0], 1'b1}; end
        else begin rem_fb <= sh_fb; q_fb <= {q_fb[9:0], 1'b0}; end
        step <= step + 5'd1;
        if (step >= 5'd7) begin
          num_ft <= {num_ft[19:0], 1'b0};
          if (!t_ft[21]) begin rem_ft <= t_ft[20:0]; q_ft <= {q_ft[5:0], 1'b1}; end
          else begin rem_ft <= sh_ft; q_ft <= {q_ft[5:0], 1'b0}; end
        end
      end
      ST_DONE: begin
        if (load) res <= res_next;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cur.header[20:19])
      2'b11:   begin ver = 2'd1; tab = 1'b0; end
      2'b10:   begin ver = 2'd2; tab = 1'b1; end
      default: begin ver = 2'd0; tab = 1'b1; end
    endcase
    lay = (cur.header[18:17] == 2'b00) ? 2'd2 : 2'(2'd3 - cur.header[18:17]);
    br  = mafs_pkg::rate_lookup(tab, lay, cur.header[15:12]);
    fs  = mafs_pkg::fs_lookup(ver, cur.header[11:10]);
  end

  // An overrun result carries only its status; every other field is zero.
  always_comb begin
    res_next = '0;
    if (cur.overrun) begin
      res_next.status = mafs_pkg::STATUS_OVERRUN;
    end else begin
      res_next.status         = mafs_pkg::STATUS_FOUND;
      res_next.skipped_bytes  = cur.skip;
      res_next.header_word    = cur.header;
      res_next.mpeg_version   = ver;
      res_next.layer_index    = lay;
      res_next.bitrate_kbps   = br;
      res_next.sample_rate_hz = fs;
      res_next.frame_bytes    = q_fb + {10'd0, cur.header[9]};
      res_next.frame_time_ms  = q_ft;
    end
  end

endmodule

// File: rtl/core/mpeg_audio_frame_sync_decoder.sv
// Top level: MPEG audio frame header sync search with decoded header results.
// One byte per cycle; full holds the input off the cycle after a search ends and while both
// queue entries are taken. A found header reaches the result ports after the 28-step serial
// divider computes frame length and time; an overrun result skips the divider.
// The back part works on one candidate at a time and takes the next only once its result is loaded.
// Synchronous active-high reset clears the window, counter, queue, control state and configuration registers.
module mpeg_audio_frame_sync_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic        status,
  output logic [23:0] skipped_bytes,
  output logic [31:0] header_word,
  output logic [1:0]  mpeg_version,
  output logic [1:0]  layer_index,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic [10:0] frame_bytes,
  output logic [6:0]  frame_time_ms
);

  logic [31:0] template_header;
  logic [23:0] max_search;
  logic        cand_valid, q_full, q_full_raw, res_valid, accept;
  mafs_pkg::mafs_cand_t   cand;
  mafs_pkg::mafs_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      template_header <= 32'd0;
      max_search      <= 24'd0;
    end else if (cfg_we) begin
      if (cfg_index == mafs_pkg::REG_TEMPLATE) template_header <= cfg_data;
      else if (cfg_index == mafs_pkg::REG_MAX_SEARCH) max_search <= cfg_data[23:0];
    end
  end

  // Also hold input off while a candidate enters the queue, so a candidate in flight always finds room.
  logic q_almost;
  assign full   = q_full || q_almost;
  assign accept = push && !full;

  mafs_front u_front (
    .clk, .rst, .in_valid(accept), .data_byte, .restart,
    .template_header, .max_search, .cand_valid, .cand
  );

  mafs_back u_back (
    .clk, .rst, .cand_valid, .cand, .q_full(q_full_raw), .res_valid,
    .res_pop(pop), .res
  );

  assign q_full   = q_full_raw;
  assign q_almost = cand_valid;

  assign empty          = !res_valid;
  assign status         = res.status;
  assign skipped_bytes  = res.skipped_bytes;
  assign header_word    = res.header_word;
  assign mpeg_version   = res.mpeg_version;
  assign layer_index    = res.layer_index;
  assign bitrate_kbps   = res.bitrate_kbps;
  assign sample_rate_hz = res.sample_rate_hz;
  assign frame_bytes    = res.frame_bytes;
  assign frame_time_ms  = res.frame_time_ms;

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !accept) else $error("byte accepted while full");
  a_overrun_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (header_word == 32'd0 && frame_bytes == 11'd0))
    else $error("overrun result carries data");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(header_word)))
    else $error("waiting result changed");

endmodule
